// ===== design/dapt_pkg.sv =====
// dapt_pkg: types, codes and character classes shared by the digest auth
// parameter tokenizer modules. No dependencies.

package dapt_pkg;

    // parser state codes
    localparam logic [2:0] ST_SPACE  = 3'd0;
    localparam logic [2:0] ST_NAME   = 3'd1;
    localparam logic [2:0] ST_EQUALS = 3'd2;
    localparam logic [2:0] ST_VALUE  = 3'd3;
    localparam logic [2:0] ST_QUOTED = 3'd4;
    localparam logic [2:0] ST_ESCAPE = 3'd5;
    localparam logic [2:0] ST_AFTER  = 3'd6;

    // request action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // character kind codes
    localparam logic [1:0] KIND_SKIP  = 2'd0;
    localparam logic [1:0] KIND_NAME  = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;

    // status codes
    localparam logic [1:0] STAT_RUN    = 2'd0;
    localparam logic [1:0] STAT_ERROR  = 2'd1;
    localparam logic [1:0] STAT_ACCEPT = 2'd2;

    // special characters
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic       action;
        logic [7:0] text_byte;
    } dapt_in_t;

    typedef struct packed {
        logic [1:0] char_kind;
        logic [7:0] out_byte;
        logic       pair_done;
        logic [1:0] status;
    } dapt_out_t;

    // parser context carried between requests
    typedef struct packed {
        logic [2:0] parse_state;
        logic       error_seen;
    } dapt_ctx_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A)
            || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

// ===== design/dapt_step.sv =====
// dapt_step: combinational parser step for one request, giving the next
// parser context and the result. Depends on dapt_pkg.

module dapt_step (
    input  dapt_pkg::dapt_ctx_t ctx,
    input  dapt_pkg::dapt_in_t  item,
    output dapt_pkg::dapt_ctx_t ctx_next,
    output dapt_pkg::dapt_out_t result
);
    import dapt_pkg::*;

    logic [7:0] c;
    logic       name_ch;
    logic       err;
    logic [2:0] st_next;
    logic [1:0] kind;
    logic [7:0] ob;
    logic       done;

    assign c       = item.text_byte;
    assign name_ch = is_alnum(c) || (c == CH_USCORE) || (c == CH_DASH);

    // state transition for a text byte
    always_comb
    begin
        err     = 1'b0;
        st_next = ctx.parse_state;
        kind    = KIND_SKIP;
        ob      = 8'd0;
        done    = 1'b0;
        unique case (ctx.parse_state)
            ST_SPACE:
            begin
                if (name_ch)
                begin
                    kind    = KIND_NAME;
                    ob      = c;
                    st_next = ST_NAME;
                end
                else if (!is_space(c))
                    err = 1'b1;
            end
            ST_NAME:
            begin
                if (c == CH_EQUALS)
                    st_next = ST_EQUALS;
                else if (name_ch)
                begin
                    kind = KIND_NAME;
                    ob   = c;
                end
                else
                    err = 1'b1;
            end
            ST_EQUALS:
            begin
                if (is_alnum(c) || c == CH_USCORE)
                begin
                    kind    = KIND_VALUE;
                    ob      = c;
                    st_next = ST_VALUE;
                end
                else if (c == CH_QUOTE)
                    st_next = ST_QUOTED;
                else
                    err = 1'b1;
            end
            ST_QUOTED:
            begin
                if (c == CH_BSLASH)
                    st_next = ST_ESCAPE;
                else if (c == CH_QUOTE)
                begin
                    done    = 1'b1;
                    st_next = ST_AFTER;
                end
                else
                begin
                    kind = KIND_VALUE;
                    ob   = c;
                end
            end
            ST_ESCAPE:
            begin
                kind    = KIND_VALUE;
                ob      = c;
                st_next = ST_QUOTED;
            end
            ST_VALUE:
            begin
                if (is_space(c))
                begin
                    done    = 1'b1;
                    st_next = ST_AFTER;
                end
                else if (c == CH_COMMA)
                begin
                    done    = 1'b1;
                    st_next = ST_SPACE;
                end
                else
                begin
                    kind = KIND_VALUE;
                    ob   = c;
                end
            end
            ST_AFTER:
            begin
                if (c == CH_COMMA)
                    st_next = ST_SPACE;
                else if (!is_space(c))
                    err = 1'b1;
            end
            default:
                err = 1'b1;
        endcase
    end

    // select between end request, ignored byte, syntax error and parsed byte
    always_comb
    begin
        ctx_next = ctx;
        result   = '{char_kind: KIND_SKIP, out_byte: 8'd0, pair_done: 1'b0,
                     status: STAT_RUN};
        if (item.action == ACT_END)
        begin
            ctx_next.parse_state = ST_SPACE;
            ctx_next.error_seen  = 1'b0;
            if (!ctx.error_seen && ctx.parse_state == ST_VALUE)
            begin
                result.pair_done = 1'b1;
                result.status    = STAT_ACCEPT;
            end
            else if (!ctx.error_seen && ctx.parse_state == ST_AFTER)
                result.status = STAT_ACCEPT;
            else
                result.status = STAT_ERROR;
        end
        else if (ctx.error_seen)
            result.status = STAT_ERROR;
        else if (err)
        begin
            ctx_next.error_seen = 1'b1;
            result.status       = STAT_ERROR;
        end
        else
        begin
            ctx_next.parse_state = st_next;
            result.char_kind     = kind;
            result.out_byte      = ob;
            result.pair_done     = done;
        end
    end

endmodule

// ===== design/digest_auth_param_tokenizer.sv =====
// digest_auth_param_tokenizer: top level, input register, parser context and
// result register around dapt_step. Depends on dapt_pkg and dapt_step.
//
// Usage:
//   Header text enters on the byte channel (byte_valid/byte_ready/byte_item),
//   one request per character, followed by an end request (action = 1).
//   Each request yields exactly one result on the token channel
//   (tok_valid/tok_ready/tok_item): the character kind, the character for
//   names and values, a pair-complete flag and the running status.
//   After a syntax error, bytes are ignored and report error until the end
//   request, which reports accept or error and returns the parser to idle.
//   A request accepted into the input register passes through the parser
//   step into the result register, where tok_valid presents it (input
//   register, then result register). Throughput: one request per cycle
//   while the receiver takes results, set by the combinational parser step
//   between the two registers.
//   Reset clears both valid flags and the parser context (leading space,
//   no error). When the receiver stalls, the result register holds and the
//   input register takes one more request; byte_ready then drops until the
//   result is taken.

module digest_auth_param_tokenizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  dapt_pkg::dapt_in_t  byte_item,
    output logic                tok_valid,
    input  logic                tok_ready,
    output dapt_pkg::dapt_out_t tok_item
);
    import dapt_pkg::*;

    logic      s1_valid_reg;
    dapt_in_t  s1_item_reg;
    logic      out_valid_reg;
    dapt_out_t out_item_reg;
    dapt_ctx_t ctx_reg;
    dapt_ctx_t ctx_next;
    dapt_out_t result;
    logic      advance;
    logic      step;

    // pipeline handshake
    assign advance    = !out_valid_reg || tok_ready;
    assign step       = s1_valid_reg && advance;
    assign byte_ready = !s1_valid_reg || advance;

    dapt_step u_step (
        .ctx      (ctx_reg),
        .item     (s1_item_reg),
        .ctx_next (ctx_next),
        .result   (result)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctx_reg       <= '{parse_state: ST_SPACE, error_seen: 1'b0};
        end
        else
        begin
            if (byte_ready)
                s1_valid_reg <= byte_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
            if (step)
                ctx_reg <= ctx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            s1_item_reg <= byte_item;
        if (step)
            out_item_reg <= result;
    end

    assign tok_valid = out_valid_reg;
    assign tok_item  = out_item_reg;

endmodule

// ===== design/dapt_checker.sv =====
// dapt_checker: port-level assertions for digest_auth_param_tokenizer and
// the bind that attaches them. Depends on dapt_pkg.

module dapt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                byte_valid,
    input logic                byte_ready,
    input logic                tok_valid,
    input logic                tok_ready,
    input dapt_pkg::dapt_out_t tok_item
);
    import dapt_pkg::*;

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok_item))
        else $error("stalled result changed");

    // an accepted request is followed by tok_valid high (input register, then result register)
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready |-> ##2 tok_valid)
        else $error("result missing after request");

    // an empty output side never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !tok_valid |-> byte_ready)
        else $error("input blocked with empty output");

    // a name or value character is only reported while running
    a_kind_running: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.char_kind != KIND_SKIP
            |-> tok_item.status == STAT_RUN && !tok_item.pair_done)
        else $error("character reported outside running status");

    // accept and error results carry no character
    a_final_empty: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.status != STAT_RUN
            |-> tok_item.char_kind == KIND_SKIP && tok_item.out_byte == 8'd0)
        else $error("final result carries a character");

endmodule

bind digest_auth_param_tokenizer dapt_checker u_dapt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok_item   (tok_item)
);
